[src/fifo_page_table_translator_defines.svh]
// Assertion macros used by the translator RTL.
// Depends on nothing; included by ptt_ctrl, the module that carries checks.
`ifndef FIFO_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define FIFO_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define PTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ptt_pkg.sv]
// Shared constants and types for the FIFO page-table translator.
// Depends on nothing; imported by every module of the block except ptt_ram.
// Page, frame and byte counts are expected to be powers of two.
package ptt_pkg;

   localparam int unsigned VIRT_PAGES_DEF  = 4096;
   localparam int unsigned PHYS_FRAMES_DEF = 64;
   localparam int unsigned PAGE_BYTES_DEF  = 4096;

   // Fixed widths of the address input and the running totals.
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned COUNT_W = 32;

   // Counter updates requested by the sequencer.
   typedef struct packed {
      logic hit_inc;
      logic fault_inc;
   } ptt_count_type;

   // Totals after the requested update.
   typedef struct packed {
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] fault_total;
   } ptt_totals_type;

endpackage

[src/fifo_page_table_translator.sv]
// FIFO page-table translator: one access per transfer, one result per access.
// The result strobe is registered out of the lookup state that follows the accepting edge.
// Busy until the lookup state ends; a fault that evicts a page adds an eviction state,
// since the page-table RAM's single write port then takes a second write for the victim.
// After reset, busy stays high while every page-table entry is cleared.
// The receiver cannot stall; results are strobed for one cycle.
module fifo_page_table_translator
   import ptt_pkg::*;
#(
   parameter int unsigned VIRT_PAGES  = VIRT_PAGES_DEF,
   parameter int unsigned PHYS_FRAMES = PHYS_FRAMES_DEF,
   parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
   localparam int unsigned VPN_W      = $clog2(VIRT_PAGES),
   localparam int unsigned FRAME_W    = $clog2(PHYS_FRAMES),
   localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [ADDR_W-1:0]  req_virtual_address,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [FRAME_W-1:0] rsp_frame,
   output logic               rsp_evicted,
   output logic [VPN_W-1:0]   rsp_evicted_page,
   output logic [COUNT_W-1:0] rsp_hit_total,
   output logic [COUNT_W-1:0] rsp_fault_total
);

   logic [ADDR_W-1:0]  page_addr;
   logic [VPN_W-1:0]   vpn;

   logic               pt_wr_en, pt_rd_en;
   logic [VPN_W-1:0]   pt_wr_addr, pt_rd_addr;
   logic [FRAME_W:0]   pt_wr_data, pt_rd_data;

   logic               own_wr_en, own_rd_en;
   logic [FRAME_W-1:0] own_wr_addr, own_rd_addr;
   logic [VPN_W-1:0]   own_wr_data, own_rd_data;

   ptt_count_type      count;
   ptt_totals_type     totals;

   // Page number: drop the byte offset, keep the page-index bits.
   assign page_addr = req_virtual_address >> PAGE_SHIFT;
   assign vpn       = page_addr[VPN_W-1:0];

   // Page table: valid bit and frame number per virtual page.
   ptt_ram #(
      .WIDTH (FRAME_W + 1),
      .DEPTH (VIRT_PAGES)
   ) u_page_table (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   // Owner page of each physical frame.
   ptt_ram #(
      .WIDTH (VPN_W),
      .DEPTH (PHYS_FRAMES)
   ) u_frame_owner (
      .clock   (clock),
      .wr_en   (own_wr_en),
      .wr_addr (own_wr_addr),
      .wr_data (own_wr_data),
      .rd_en   (own_rd_en),
      .rd_addr (own_rd_addr),
      .rd_data (own_rd_data)
   );

   ptt_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .count  (count),
      .totals (totals)
   );

   ptt_ctrl #(
      .VIRT_PAGES  (VIRT_PAGES),
      .PHYS_FRAMES (PHYS_FRAMES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .vpn              (vpn),
      .pt_wr_en         (pt_wr_en),
      .pt_wr_addr       (pt_wr_addr),
      .pt_wr_data       (pt_wr_data),
      .pt_rd_en         (pt_rd_en),
      .pt_rd_addr       (pt_rd_addr),
      .pt_rd_data       (pt_rd_data),
      .own_wr_en        (own_wr_en),
      .own_wr_addr      (own_wr_addr),
      .own_wr_data      (own_wr_data),
      .own_rd_en        (own_rd_en),
      .own_rd_addr      (own_rd_addr),
      .own_rd_data      (own_rd_data),
      .count            (count),
      .totals           (totals),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_frame        (rsp_frame),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_fault_total  (rsp_fault_total)
   );

endmodule

[src/ptt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ptt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/ptt_stats.sv]
// Saturating hit and fault counters of the translator.
// Depends on ptt_pkg.
module ptt_stats
   import ptt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ptt_count_type  count,
   output ptt_totals_type totals
);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0] fault_count_ff, fault_count_in;

   // Next values hold at the maximum rather than wrapping.
   always_comb begin
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      if (count.hit_inc && (hit_count_ff != COUNT_MAX)) begin
         hit_count_in = hit_count_ff + COUNT_W'(1);
      end
      if (count.fault_inc && (fault_count_ff != COUNT_MAX)) begin
         fault_count_in = fault_count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
      end else begin
         hit_count_ff   <= hit_count_in;
         fault_count_ff <= fault_count_in;
      end
   end

   // The totals include the access being counted in this cycle.
   assign totals.hit_total   = hit_count_in;
   assign totals.fault_total = fault_count_in;

endmodule

[src/ptt_ctrl.sv]
// Sequencer of the translator: clearing pass, lookup, mapping and eviction.
// Depends on ptt_pkg and the assertion macros; drives both table RAMs.
`include "fifo_page_table_translator_defines.svh"

module ptt_ctrl
   import ptt_pkg::*;
#(
   parameter int unsigned VIRT_PAGES  = VIRT_PAGES_DEF,
   parameter int unsigned PHYS_FRAMES = PHYS_FRAMES_DEF,
   localparam int unsigned VPN_W      = $clog2(VIRT_PAGES),
   localparam int unsigned FRAME_W    = $clog2(PHYS_FRAMES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VPN_W-1:0]   vpn,
   // Page table: valid bit above the frame number.
   output logic               pt_wr_en,
   output logic [VPN_W-1:0]   pt_wr_addr,
   output logic [FRAME_W:0]   pt_wr_data,
   output logic               pt_rd_en,
   output logic [VPN_W-1:0]   pt_rd_addr,
   input  logic [FRAME_W:0]   pt_rd_data,
   // Frame owner table.
   output logic               own_wr_en,
   output logic [FRAME_W-1:0] own_wr_addr,
   output logic [VPN_W-1:0]   own_wr_data,
   output logic               own_rd_en,
   output logic [FRAME_W-1:0] own_rd_addr,
   input  logic [VPN_W-1:0]   own_rd_data,
   // Counters.
   output ptt_count_type      count,
   input  ptt_totals_type     totals,
   // Result.
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [FRAME_W-1:0] rsp_frame,
   output logic               rsp_evicted,
   output logic [VPN_W-1:0]   rsp_evicted_page,
   output logic [COUNT_W-1:0] rsp_hit_total,
   output logic [COUNT_W-1:0] rsp_fault_total
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EVICT
   } state_type;

   localparam logic [VPN_W-1:0]   LAST_PAGE  = VPN_W'(VIRT_PAGES - 1);
   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(PHYS_FRAMES - 1);

   state_type          state_ff;
   logic [VPN_W-1:0]   clr_idx_ff;
   logic [VPN_W-1:0]   vpn_ff;
   logic [FRAME_W-1:0] next_frame_ff;
   logic [PHYS_FRAMES-1:0] owned_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_evicted_ff;
   logic [VPN_W-1:0]   rsp_evicted_page_ff;
   logic [COUNT_W-1:0] rsp_hit_total_ff;
   logic [COUNT_W-1:0] rsp_fault_total_ff;

   logic               lk_valid;
   logic [FRAME_W-1:0] lk_frame;
   logic               victim_owned;

   assign lk_valid     = pt_rd_data[FRAME_W];
   assign lk_frame     = pt_rd_data[FRAME_W-1:0];
   assign victim_owned = owned_ff[next_frame_ff];
   assign busy         = (state_ff != ST_IDLE);

   // Both tables are read in the cycle a request is taken.
   assign pt_rd_en    = start && (state_ff == ST_IDLE);
   assign pt_rd_addr  = vpn;
   assign own_rd_en   = start && (state_ff == ST_IDLE);
   assign own_rd_addr = next_frame_ff;

   // Table writes: clearing sweep, new mapping on a fault, invalidation of the victim.
   always_comb begin
      pt_wr_en    = 1'b0;
      pt_wr_addr  = vpn_ff;
      pt_wr_data  = '0;
      own_wr_en   = 1'b0;
      own_wr_addr = next_frame_ff;
      own_wr_data = vpn_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            pt_wr_en   = 1'b1;
            pt_wr_addr = clr_idx_ff;
         end
         ST_LOOKUP: begin
            if (!lk_valid) begin
               pt_wr_en   = 1'b1;
               pt_wr_data = {1'b1, next_frame_ff};
               own_wr_en  = 1'b1;
            end
         end
         ST_EVICT: begin
            pt_wr_en   = 1'b1;
            pt_wr_addr = rsp_evicted_page_ff;
         end
         default: begin
         end
      endcase
   end

   assign count.hit_inc   = (state_ff == ST_LOOKUP) && lk_valid;
   assign count.fault_inc = (state_ff == ST_LOOKUP) && !lk_valid;

   // State, FIFO pointer, owner-valid bits and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         next_frame_ff <= '0;
         owned_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + VPN_W'(1);
               if (clr_idx_ff == LAST_PAGE) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  vpn_ff   <= vpn;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               rsp_valid_ff       <= 1'b1;
               rsp_hit_total_ff   <= totals.hit_total;
               rsp_fault_total_ff <= totals.fault_total;
               if (lk_valid) begin
                  rsp_hit_ff          <= 1'b1;
                  rsp_frame_ff        <= lk_frame;
                  rsp_evicted_ff      <= 1'b0;
                  rsp_evicted_page_ff <= '0;
                  state_ff            <= ST_IDLE;
               end else begin
                  rsp_hit_ff              <= 1'b0;
                  rsp_frame_ff            <= next_frame_ff;
                  rsp_evicted_ff          <= victim_owned;
                  rsp_evicted_page_ff     <= victim_owned ? own_rd_data : '0;
                  owned_ff[next_frame_ff] <= 1'b1;
                  next_frame_ff <= (next_frame_ff == LAST_FRAME) ? '0
                                                                 : next_frame_ff + FRAME_W'(1);
                  state_ff <= victim_owned ? ST_EVICT : ST_IDLE;
               end
            end
            ST_EVICT: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_hit_total    = rsp_hit_total_ff;
   assign rsp_fault_total  = rsp_fault_total_ff;

   // A victim page is always a mapped page, so it never equals the faulting page.
   `PTT_ASSERT_NOW(a_victim_not_self, clock, reset, rsp_valid_ff && rsp_evicted_ff,
                   rsp_evicted_page_ff != vpn_ff, "evicted page equals accessed page")
   // An eviction result is followed by the invalidation write.
   `PTT_ASSERT_NOW(a_evict_writes, clock, reset, rsp_valid_ff && rsp_evicted_ff,
                   state_ff == ST_EVICT, "eviction without invalidation cycle")
   // An eviction only happens on a fault.
   `PTT_ASSERT_NOW(a_evict_is_fault, clock, reset, rsp_valid_ff && rsp_evicted_ff,
                   !rsp_hit_ff, "eviction reported on a hit")
   // Each result comes from exactly one lookup cycle.
   `PTT_ASSERT_NOW(a_rsp_from_lookup, clock, reset, rsp_valid_ff,
                   $past(state_ff) == ST_LOOKUP, "result without lookup")
   // An accepted request is looked up in the following cycle.
   `PTT_ASSERT_NEXT(a_accept_lookup, clock, reset, start && (state_ff == ST_IDLE),
                    state_ff == ST_LOOKUP, "accepted request not looked up")

endmodule
